### hw/rtl/fmr_pkg.sv
// Shared types and constants for the frame min/max rescaler.
package fmr_pkg;

    localparam int unsigned FRAME_PIXELS_DEF = 4096;
    localparam int unsigned CMD_DEPTH        = 2;
    localparam int unsigned SAMPLE_W         = 32;
    localparam int unsigned PIXEL_W          = 16;
    localparam int unsigned PROD_W           = SAMPLE_W + PIXEL_W;

    localparam logic [PIXEL_W-1:0] PIX_SCALE = 16'hFFFF;
    localparam logic [PIXEL_W-1:0] PIX_FLAT  = 16'h8000;
    localparam logic [PIXEL_W-1:0] PIX_ZERO  = 16'h0000;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_VALID = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_is_nan;
        logic                       last_sample;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic               last_pixel;
        status_t            status;
    } out_item_t;

    // One queued fetch: either a finished pixel or a division to run.
    typedef struct packed {
        logic                div_en;
        logic [PIXEL_W-1:0]  pixel;
        logic                last;
        status_t             status;
        logic [SAMPLE_W-1:0] diff;
        logic [SAMPLE_W-1:0] range;
    } cmd_t;

endpackage

### hw/rtl/fmr_cmd_fifo.sv
// Small register queue carrying fetch commands from front to back.
module fmr_cmd_fifo #(
    parameter int unsigned DEPTH = fmr_pkg::CMD_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  fmr_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output fmr_pkg::cmd_t pop_data,
    output logic          empty
);
    import fmr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Front and back must honor full/empty.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command queue overrun");

endmodule

### hw/rtl/fmr_front.sv
// Front part: frame store, min/max tracking, fetch classification.
module fmr_front #(
    parameter int unsigned FRAME_PIXELS = fmr_pkg::FRAME_PIXELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fmr_pkg::in_item_t s_item,
    output logic              cmd_push,
    output fmr_pkg::cmd_t     cmd_data,
    input  logic              cmd_full
);
    import fmr_pkg::*;

    localparam int unsigned ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int unsigned CNT_W  = $clog2(FRAME_PIXELS + 1);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_EVAL = 2'b10
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [SAMPLE_W:0] store_mem [FRAME_PIXELS];
    logic [SAMPLE_W:0] rd_data_reg;

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           rp_reg, rp_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic                       seen_reg, seen_next;
    logic                       ovf_reg, ovf_next;
    logic                       closed_reg, closed_next;

    logic    last_reg, last_next;
    status_t status_reg, status_next;

    logic                       accept;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [CNT_W-1:0]           cnt_eff;
    logic signed [SAMPLE_W-1:0] min_eff, max_eff;
    logic                       seen_eff;
    logic [CNT_W-1:0]           idx;
    logic                       idx_last;
    logic signed [SAMPLE_W-1:0] rd_value;

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;

    // Fetch index: wraps to the start once past what has been loaded.
    assign idx      = (rp_reg >= cnt_reg) ? '0 : rp_reg;
    assign idx_last = ((idx + 1'b1) == cnt_reg);

    // A load into a closed frame starts a fresh one.
    assign cnt_eff  = closed_reg ? '0 : cnt_reg;
    assign min_eff  = closed_reg ? '0 : min_reg;
    assign max_eff  = closed_reg ? '0 : max_reg;
    assign seen_eff = closed_reg ? 1'b0 : seen_reg;
    assign wr_addr  = cnt_eff[ADDR_W-1:0];

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rp_next     = rp_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        seen_next   = seen_reg;
        ovf_next    = ovf_reg;
        closed_next = closed_reg;
        last_next   = last_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        cmd_push    = 1'b0;

        case (state_reg)
            F_IDLE: begin
                if (accept && s_item.action == ACT_LOAD) begin
                    cnt_next  = cnt_eff;
                    min_next  = min_eff;
                    max_next  = max_eff;
                    seen_next = seen_eff;
                    ovf_next  = closed_reg ? 1'b0 : ovf_reg;
                    if (closed_reg) begin
                        rp_next = '0;
                    end
                    if (cnt_eff == CNT_W'(FRAME_PIXELS)) begin
                        ovf_next = 1'b1;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_eff + 1'b1;
                        if (!s_item.sample_is_nan) begin
                            if (!seen_eff || s_item.sample_value < min_eff) begin
                                min_next = s_item.sample_value;
                            end
                            if (!seen_eff || s_item.sample_value > max_eff) begin
                                max_next = s_item.sample_value;
                            end
                            seen_next = 1'b1;
                        end
                    end
                    closed_next = s_item.last_sample;
                end else if (accept) begin
                    state_next = F_EVAL;
                    if (cnt_reg == '0) begin
                        status_next = STATUS_EMPTY;
                        last_next   = 1'b0;
                    end else begin
                        last_next = idx_last;
                        rp_next   = idx_last ? '0 : idx + 1'b1;
                        if (ovf_reg) begin
                            status_next = STATUS_OVERFLOW;
                        end else if (!seen_reg) begin
                            status_next = STATUS_NO_VALID;
                        end else begin
                            status_next = STATUS_OK;
                        end
                    end
                end
            end
            F_EVAL: begin
                if (!cmd_full) begin
                    cmd_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Classify the fetched entry; min/max cannot move while in F_EVAL.
    assign rd_value = rd_data_reg[SAMPLE_W-1:0];

    always_comb begin
        cmd_data        = '0;
        cmd_data.last   = last_reg;
        cmd_data.status = status_reg;
        cmd_data.diff   = rd_value - min_reg;
        cmd_data.range  = max_reg - min_reg;
        cmd_data.pixel  = PIX_ZERO;
        if (status_reg == STATUS_OK) begin
            if (rd_data_reg[SAMPLE_W]) begin
                cmd_data.pixel = PIX_ZERO;
            end else if (max_reg == min_reg) begin
                cmd_data.pixel = PIX_FLAT;
            end else begin
                cmd_data.div_en = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            rp_reg     <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            seen_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rp_reg     <= rp_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            seen_reg   <= seen_next;
            ovf_reg    <= ovf_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= {s_item.sample_is_nan, s_item.sample_value};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_item.action == ACT_FETCH) begin
            rd_data_reg <= store_mem[idx[ADDR_W-1:0]];
        end
    end

    a_rp_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (rp_reg < cnt_reg) || (rp_reg == '0))
        else $error("read pointer past loaded entries");

    a_minmax_order: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (min_reg <= max_reg))
        else $error("frame minimum above maximum");

endmodule

### hw/rtl/fmr_back.sv
// Back part: scaling multiply, radix-2 divider and result register.
module fmr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_empty,
    input  fmr_pkg::cmd_t      cmd_data,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output fmr_pkg::out_item_t m_item
);
    import fmr_pkg::*;

    localparam int unsigned STEP_W = $clog2(PIXEL_W);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [SAMPLE_W-1:0] diff_reg;
    logic [SAMPLE_W-1:0] range_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [PIXEL_W-1:0]  quo_reg;
    logic [STEP_W-1:0]   step_reg;
    out_item_t           out_reg;

    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   trial_sub;
    logic                ge;
    logic [SAMPLE_W-1:0] rem_step;
    logic [PIXEL_W-1:0]  quo_step;

    assign cmd_pop = (state_reg == B_IDLE) && !cmd_empty;
    assign m_valid = (state_reg == B_OUT);
    assign m_item  = out_reg;

    // diff * 65535 stays below range * 2^16, so the quotient fits 16 bits.
    assign prod = PROD_W'(diff_reg) * PROD_W'(PIX_SCALE);

    assign trial     = {rem_reg, quo_reg[PIXEL_W-1]};
    assign trial_sub = trial - {1'b0, range_reg};
    assign ge        = (trial >= {1'b0, range_reg});
    assign rem_step  = ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
    assign quo_step  = {quo_reg[PIXEL_W-2:0], ge};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!cmd_empty) begin
                    state_next = cmd_data.div_en ? B_MUL : B_OUT;
                end
            end
            B_MUL: begin
                state_next = B_DIV;
            end
            B_DIV: begin
                if (step_reg == STEP_W'(PIXEL_W - 1)) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (!cmd_empty) begin
                    diff_reg           <= cmd_data.diff;
                    range_reg          <= cmd_data.range;
                    out_reg.pixel_value <= cmd_data.pixel;
                    out_reg.last_pixel  <= cmd_data.last;
                    out_reg.status      <= cmd_data.status;
                end
            end
            B_MUL: begin
                rem_reg  <= prod[PROD_W-1:PIXEL_W];
                quo_reg  <= prod[PIXEL_W-1:0];
                step_reg <= '0;
            end
            B_DIV: begin
                rem_reg  <= rem_step;
                quo_reg  <= quo_step;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(PIXEL_W - 1)) begin
                    out_reg.pixel_value <= quo_step;
                end
            end
            default: begin
            end
        endcase
    end

    a_rem_below_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (rem_reg < range_reg))
        else $error("divider remainder not below range");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> (state_reg == B_MUL || state_reg == B_OUT))
        else $error("popped command not taken up");

endmodule

### hw/rtl/float_frame_minmax_rescale_unit.sv
// Top level of the frame min/max rescaler to unsigned 16-bit pixels.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | s_valid / s_ready  | s_item (action, sample, nan, last)
//  m_      | out       | m_valid / m_ready  | m_item (pixel, last_pixel, status)
//
// A load gives no result. A fetch passes the front (store read, classify)
// and then the back (queue pop, result) when no division is needed, or
// (queue pop, multiply, 16 restoring divider steps, result) when it is;
// the back takes no new fetch until its result is accepted, so the
// 16-step divider sets the sustained fetch rate.
// Reset (aresetn low, synchronous) empties the frame; the store keeps junk.
// A stalled m_ready backs up the command queue, then the front; loads keep
// flowing behind pending fetches until a fetch waits in the front for room.
module float_frame_minmax_rescale_unit #(
    parameter int unsigned FRAME_PIXELS = fmr_pkg::FRAME_PIXELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fmr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output fmr_pkg::out_item_t m_item
);
    import fmr_pkg::*;

    // Front to queue
    logic cmd_push;
    cmd_t cmd_push_data;
    logic cmd_full;

    // Queue to back
    logic cmd_pop;
    cmd_t cmd_pop_data;
    logic cmd_empty;

    // Front: owns the frame store, min/max and read pointer; every fetch is
    // resolved here to a finished pixel or to a (diff, range) division job.
    fmr_front #(
        .FRAME_PIXELS(FRAME_PIXELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .cmd_push (cmd_push),
        .cmd_data (cmd_push_data),
        .cmd_full (cmd_full)
    );

    // Jobs carry their own diff and range, so later loads cannot disturb them.
    fmr_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_pop_data),
        .empty     (cmd_empty)
    );

    // Back: floor(diff * 65535 / range) for division jobs, and the result register.
    fmr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_pop_data),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

### tb/float_frame_minmax_rescale_unit_tb.sv
// Self-checking testbench for the frame min/max rescaler: directed table and random frames.
module float_frame_minmax_rescale_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmr_pkg::*;

    localparam int unsigned STORE_DEPTH  = FRAME_PIXELS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 64;    // idle margin after the last expected pixel
    localparam int unsigned PHASE_ITEMS  = 440;   // random items per idling phase

    // One row of the directed table. Rows with typed set carry an expected
    // pixel that is obvious by inspection; the rest go through the predictor.
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    float_frame_minmax_rescale_unit #(
        .FRAME_PIXELS(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // ------------------------------------------------------------------
    // Predictor state: the frame as the block should hold it.
    // ------------------------------------------------------------------
    logic [32:0] sample_store [STORE_DEPTH];  // bit 32 = NaN flag
    longint      frame_lo;
    longint      frame_hi;
    bit          any_valid;
    int unsigned fill_count;
    int unsigned rd_idx;
    bit          load_overflow;
    bit          frame_done;

    out_item_t   pending_pixels [$];  // expected pixels, oldest first

    // Run controls shared with the idling processes.
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned hold_requests;
    int unsigned holds_done;

    int unsigned cycle_count;
    int unsigned load_count;
    int unsigned fetch_count;
    int unsigned pixels_checked;
    int unsigned mismatch_count;
    int unsigned status_hits [4];

    // Works out the pixel that one accepted item causes, if any, and moves
    // the predicted frame state along.
    function automatic bit predict_pixel(input in_item_t it, output out_item_t px);
        longint      v;
        longint      diff;
        longint      span;
        longint      scaled;
        int unsigned idx;
        bit          is_last;
        logic [32:0] entry;
        px = '0;
        if (it.action == ACT_LOAD) begin
            // A load after a closed frame starts a fresh one.
            if (frame_done) begin
                fill_count    = 0;
                rd_idx        = 0;
                frame_lo      = 0;
                frame_hi      = 0;
                any_valid     = 0;
                load_overflow = 0;
                frame_done    = 0;
            end
            if (fill_count >= STORE_DEPTH) begin
                load_overflow = 1;
            end else begin
                sample_store[fill_count] = {it.sample_is_nan, it.sample_value};
                fill_count++;
                if (!it.sample_is_nan) begin
                    v = longint'($signed(it.sample_value));
                    if (!any_valid || v < frame_lo) frame_lo = v;
                    if (!any_valid || v > frame_hi) frame_hi = v;
                    any_valid = 1;
                end
            end
            if (it.last_sample) frame_done = 1;
            return 1'b0;
        end
        if (fill_count == 0) begin
            px.status = STATUS_EMPTY;
            return 1'b1;
        end
        idx = rd_idx;
        if (idx >= fill_count) idx = 0;
        is_last = (idx + 1 == fill_count);
        if (load_overflow) begin
            px.status = STATUS_OVERFLOW;
        end else if (!any_valid) begin
            px.status = STATUS_NO_VALID;
        end else begin
            px.status = STATUS_OK;
            entry = sample_store[idx];
            if (entry[32]) begin
                px.pixel_value = PIX_ZERO;
            end else if (frame_hi == frame_lo) begin
                px.pixel_value = PIX_FLAT;
            end else begin
                v      = longint'($signed(entry[31:0]));
                diff   = v - frame_lo;
                span   = frame_hi - frame_lo;
                scaled = (diff * 65535) / span;
                px.pixel_value = scaled[15:0];
            end
        end
        px.last_pixel = is_last;
        rd_idx = is_last ? 0 : idx + 1;
        return 1'b1;
    endfunction

    function automatic dir_row_t row_load(input logic [31:0] val, input bit nan, input bit last);
        dir_row_t r;
        r = '0;
        r.item.action        = ACT_LOAD;
        r.item.sample_value  = val;
        r.item.sample_is_nan = nan;
        r.item.last_sample   = last;
        return r;
    endfunction

    function automatic dir_row_t row_fetch();
        dir_row_t r;
        r = '0;
        r.item.action = ACT_FETCH;
        return r;
    endfunction

    function automatic dir_row_t row_fetch_is(input logic [15:0] pix, input bit last,
                                              input status_t st);
        dir_row_t r;
        r = row_fetch();
        r.typed            = 1'b1;
        r.want.pixel_value = pix;
        r.want.last_pixel  = last;
        r.want.status      = st;
        return r;
    endfunction

    // Offers one item: random idle gap first, then valid held with a stable
    // payload until the block takes it. Inputs move on the falling edge only.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t px;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.action == ACT_FETCH) fetch_count++;
        else load_count++;
        if (predict_pixel(it, px)) pending_pixels.push_back(typed ? want : px);
    endtask

    // Random frames: mostly well-formed load/readout sequences with random
    // content, plus dropped or early frame ends, stray fetches and noise.
    task automatic run_frames(input int unsigned quota);
        int unsigned sent;
        int unsigned n;
        int unsigned m;
        int unsigned mode;
        int unsigned nan_pct;
        int unsigned shift;
        bit          drop_last;
        logic [31:0] base;
        in_item_t    it;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(11) == 0) begin
                // noise burst: every field random
                n = $urandom_range(6, 1);
                for (int unsigned i = 0; i < n; i++) begin
                    it.action        = 1'($urandom_range(1));
                    it.sample_value  = $urandom;
                    it.sample_is_nan = 1'($urandom_range(1));
                    it.last_sample   = 1'($urandom_range(1));
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end else begin
                n         = ($urandom_range(9) == 0) ? $urandom_range(64, 17)
                                                     : $urandom_range(16, 1);
                mode      = $urandom_range(3);
                base      = $urandom;
                shift     = $urandom_range(24, 1);
                drop_last = ($urandom_range(9) == 0);
                case ($urandom_range(3))
                    0: nan_pct = 0;
                    1: nan_pct = 10;
                    2: nan_pct = 50;
                    default: nan_pct = 100;
                endcase
                for (int unsigned i = 0; i < n; i++) begin
                    if ($urandom_range(19) == 0) begin
                        // fetch in the middle of a load
                        it.action        = ACT_FETCH;
                        it.sample_value  = $urandom;
                        it.sample_is_nan = 1'($urandom_range(1));
                        it.last_sample   = 1'($urandom_range(1));
                        send_item(it, 1'b0, '0);
                        sent++;
                    end
                    it.action = ACT_LOAD;
                    case (mode)
                        0: it.sample_value = $urandom;
                        1: it.sample_value = base + ($urandom & ((32'd1 << shift) - 1));
                        2: it.sample_value = base;
                        default: begin
                            case ($urandom_range(3))
                                0: it.sample_value = 32'h8000_0000;
                                1: it.sample_value = 32'h7FFF_FFFF;
                                2: it.sample_value = 32'h0000_0000;
                                default: it.sample_value = 32'hFFFF_FFFF;
                            endcase
                        end
                    endcase
                    it.sample_is_nan = ($urandom_range(99) < nan_pct);
                    it.last_sample   = ((i == n - 1) && !drop_last) || ($urandom_range(49) == 0);
                    send_item(it, 1'b0, '0);
                    sent++;
                end
                m = ($urandom_range(4) == 0) ? $urandom_range(n) : n + $urandom_range(2);
                for (int unsigned i = 0; i < m; i++) begin
                    it.action        = ACT_FETCH;
                    it.sample_value  = $urandom;
                    it.sample_is_nan = 1'($urandom_range(1));
                    it.last_sample   = 1'($urandom_range(1));
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d pixels outstanding",
                         cycle_count, pending_pixels.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request. The hold is
    // timed here so the sender keeps offering items while the block backs up.
    // ------------------------------------------------------------------
    initial begin
        m_ready    = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_done) begin
                for (int unsigned n = 0; n < HOLD_CYCLES; n++) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
                holds_done++;
            end
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted pixel against the oldest expectation.
    // ------------------------------------------------------------------
    initial begin
        out_item_t want;
        pixels_checked = 0;
        mismatch_count = 0;
        foreach (status_hits[k]) status_hits[k] = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected pixel: pix=%0d last=%0b status=%0d",
                                 m_item.pixel_value, m_item.last_pixel, m_item.status);
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    status_hits[want.status]++;
                    if (m_item.pixel_value !== want.pixel_value ||
                        m_item.last_pixel !== want.last_pixel ||
                        m_item.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"pixel %0d mismatch: expected pix=%0d last=%0b ",
                                      "status=%0d, got pix=%0d last=%0b status=%0d"},
                                     pixels_checked, want.pixel_value, want.last_pixel,
                                     want.status, m_item.pixel_value, m_item.last_pixel,
                                     m_item.status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        dir_row_t directed_rows [$];
        int unsigned idle_plan [4];
        int unsigned stall_plan [4];

        // known values on every input from time zero
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_item        = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_requests = 0;
        load_count    = 0;
        fetch_count   = 0;

        // predicted state after reset
        frame_lo      = 0;
        frame_hi      = 0;
        any_valid     = 0;
        fill_count    = 0;
        rd_idx        = 0;
        load_overflow = 0;
        frame_done    = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_rows = {
            // fetch with nothing loaded
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_EMPTY),
            // full-range frame: both extremes, a NaN, and zero
            row_load(32'h8000_0000, 1'b0, 1'b0),
            row_load(32'h7FFF_FFFF, 1'b0, 1'b0),
            row_load(32'h5A5A_A5A5, 1'b1, 1'b0),
            row_load(32'h0000_0000, 1'b0, 1'b1),
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_OK),
            row_fetch_is(PIX_SCALE, 1'b0, STATUS_OK),
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_OK),
            row_fetch(),
            // readout wraps to the first pixel
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_OK),
            // constant frame with a NaN in it
            row_load(32'h0064_0000, 1'b0, 1'b0),
            row_load(32'hFFFF_FFFF, 1'b1, 1'b0),
            row_load(32'h0064_0000, 1'b0, 1'b1),
            row_fetch_is(PIX_FLAT, 1'b0, STATUS_OK),
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_OK),
            row_fetch_is(PIX_FLAT, 1'b1, STATUS_OK),
            // frame with no valid sample
            row_load(32'h1234_5678, 1'b1, 1'b0),
            row_load(32'h8765_4321, 1'b1, 1'b1),
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_NO_VALID),
            row_fetch_is(PIX_ZERO, 1'b1, STATUS_NO_VALID),
            // fetch while the frame is still loading
            row_load(32'h0005_0000, 1'b0, 1'b0),
            row_fetch_is(PIX_FLAT, 1'b1, STATUS_OK),
            row_load(32'h000A_0000, 1'b0, 1'b1),
            row_fetch_is(PIX_ZERO, 1'b0, STATUS_OK),
            row_fetch_is(PIX_SCALE, 1'b1, STATUS_OK)
        };
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // Random phases: none, sender idle, receiver stalling, both.
        idle_plan  = '{0, 77, 0, 29};
        stall_plan = '{0, 0, 77, 29};
        for (int unsigned p = 0; p < 4; p++) begin
            src_idle_pct  = idle_plan[p];
            snk_stall_pct = stall_plan[p];
            if (p == 0) hold_requests++;  // back the block up once
            run_frames(PHASE_ITEMS);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d loads and %0d fetches; %0d pixels checked, %0d mismatches",
                 load_count, fetch_count, pixels_checked, mismatch_count);
        $display("status mix: ok %0d, no valid %0d, empty %0d, overflow %0d",
                 status_hits[STATUS_OK], status_hits[STATUS_NO_VALID],
                 status_hits[STATUS_EMPTY], status_hits[STATUS_OVERFLOW]);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
